FILE: sv/mrdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdf_pkg: shared types and constants for the mesh repeater dedup unit
// Register map codes, configuration bundle, header word layout.
// ----------------------------------------------------------------------------
package mrdf_pkg;

  localparam int RING_DEPTH = 8;
  localparam int RING_PTR_W = $clog2(RING_DEPTH);

  localparam int ID_W    = 32;
  localparam int UID_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int DELAY_W = 20;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [DELAY_W-1:0] SLOT_TIME_US = DELAY_W'(3000);
  localparam logic [BYTE_W-1:0]  SLOT_RESET   = BYTE_W'(2);

  typedef enum logic [2:0] {
    REG_SPECIES   = 3'd0,
    REG_REPEATER  = 3'd1,
    REG_SLOT      = 3'd2,
    REG_OWN_UID   = 3'd3,
    REG_CODE_UP   = 3'd4,
    REG_CODE_DOWN = 3'd5,
    REG_CODE_ACK  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] code_ack;
    logic [BYTE_W-1:0] code_down;
    logic [BYTE_W-1:0] code_up;
    logic [UID_W-1:0]  own_uid;
    logic [BYTE_W-1:0] slot_number;
    logic [BYTE_W-1:0] repeater_code;
    logic [BYTE_W-1:0] species_code;
  } cfg_t;

  // header word, last declared field (msg_type) in the lowest bits
  typedef struct packed {
    logic [BYTE_W-1:0] in_tag_c;
    logic [BYTE_W-1:0] in_tag_b;
    logic [BYTE_W-1:0] in_tag_a;
    logic [BYTE_W-1:0] nf_dbm;
    logic [BYTE_W-1:0] rssi;
    logic [BYTE_W-1:0] hdr_channel;
    logic [BYTE_W-1:0] sender_addr;
    logic [UID_W-1:0]  dest_uid;
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] msg_type;
  } hdr_word_t;

  localparam int IN_W = $bits(hdr_word_t);

  typedef struct packed {
    logic [3:0]         pad;
    logic [BYTE_W-1:0]  learned_channel;
    logic [DELAY_W-1:0] send_delay_us;
    logic [BYTE_W-1:0]  out_tag_c;
    logic [BYTE_W-1:0]  out_tag_b;
    logic [BYTE_W-1:0]  out_tag_a;
    logic [BYTE_W-1:0]  out_sender_addr;
  } res_word_t;

  localparam int OUT_W = $bits(res_word_t);

  typedef struct packed {
    logic toward_device;
    logic forward;
  } res_user_t;

endpackage

FILE: sv/mrdf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdf_cfg: configuration registers
// APB-style register file; pready is tied high and read-back is combinational.
// ----------------------------------------------------------------------------
module mrdf_cfg
  import mrdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SPECIES:   cfg_d.species_code  = pwdata[BYTE_W-1:0];
        REG_REPEATER:  cfg_d.repeater_code = pwdata[BYTE_W-1:0];
        REG_SLOT:      cfg_d.slot_number   = pwdata[BYTE_W-1:0];
        REG_OWN_UID:   cfg_d.own_uid       = pwdata[UID_W-1:0];
        REG_CODE_UP:   cfg_d.code_up       = pwdata[BYTE_W-1:0];
        REG_CODE_DOWN: cfg_d.code_down     = pwdata[BYTE_W-1:0];
        REG_CODE_ACK:  cfg_d.code_ack      = pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPECIES:   prdata = DATA_W'(cfg_q.species_code);
      REG_REPEATER:  prdata = DATA_W'(cfg_q.repeater_code);
      REG_SLOT:      prdata = DATA_W'(cfg_q.slot_number);
      REG_OWN_UID:   prdata = DATA_W'(cfg_q.own_uid);
      REG_CODE_UP:   prdata = DATA_W'(cfg_q.code_up);
      REG_CODE_DOWN: prdata = DATA_W'(cfg_q.code_down);
      REG_CODE_ACK:  prdata = DATA_W'(cfg_q.code_ack);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_t'{slot_number: SLOT_RESET, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: sv/mrdf_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdf_ring: ring of recent frame ids
// Parallel lookup over valid entries, insert at the pointer and advance.
// ----------------------------------------------------------------------------
module mrdf_ring
  import mrdf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] id_i,
  input  logic            insert_i,
  output logic            hit_o
);

  logic [ID_W-1:0]       ids_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q, valid_d;
  logic [RING_PTR_W-1:0] ptr_q, ptr_d;

  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      hit_o = hit_o | (valid_q[i] & (ids_q[i] == id_i));
    end
  end

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (insert_i) begin
      valid_d[ptr_q] = 1'b1;
      ptr_d = (ptr_q == RING_PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert_i) begin
      ids_q[ptr_q] <= id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

endmodule

FILE: sv/mesh_repeater_dedup_forward_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_repeater_dedup_forward_unit: duplicate-filtering mesh repeater
// Pipeline: an accepted header word is held in the input register, its result in the result register.
// Throughput: one word per cycle; the input register and result register
// advance together, limited only by m_axis_tready.
// Reset: both rings empty, pointers and learned channel zero, slot = 2.
// ----------------------------------------------------------------------------
module mesh_repeater_dedup_forward_unit
  import mrdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // slave stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [7:0] msg_type, [39:8] frame_id, [55:40] dest_uid, [63:56] sender_addr,
  // [71:64] hdr_channel, [79:72] rssi, [87:80] nf_dbm,
  // [95:88] in_tag_a, [103:96] in_tag_b, [111:104] in_tag_c
  input  logic [IN_W-1:0]   s_axis_tdata,
  // master stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [7:0] out_sender_addr, [15:8] out_tag_a, [23:16] out_tag_b,
  // [31:24] out_tag_c, [51:32] send_delay_us, [59:52] learned_channel, zero pad
  output logic [OUT_W-1:0]  m_axis_tdata,
  // [0] forward, [1] toward_device
  output logic [1:0]        m_axis_tuser,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  hdr_word_t in_q;
  logic      in_valid_q, in_valid_d;
  res_word_t res_q, res_d;
  res_user_t user_q, user_d;
  logic      out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] chan_q, chan_d, chan_next;

  logic s_accept, m_accept, advance;
  logic repeating, is_up, is_down, first_hop;
  logic up_hit, down_hit, up_fwd, down_fwd, fwd;
  logic [BYTE_W-1:0] own_addr;

  mrdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mrdf_ring u_up_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .id_i     (in_q.frame_id),
    .insert_i (advance & up_fwd),
    .hit_o    (up_hit)
  );

  mrdf_ring u_down_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .id_i     (in_q.frame_id),
    .insert_i (advance & down_fwd),
    .hit_o    (down_hit)
  );

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign m_accept      = m_axis_tvalid & m_axis_tready;

  assign repeating = (cfg.species_code == cfg.repeater_code);
  assign own_addr  = cfg.species_code + cfg.slot_number;
  assign is_up     = (in_q.msg_type == cfg.code_up);
  assign is_down   = ~is_up & (in_q.msg_type == cfg.code_down);
  assign first_hop = (in_q.sender_addr < cfg.repeater_code);
  assign up_fwd    = is_up & repeating & ~up_hit;
  assign down_fwd  = is_down & repeating & (in_q.dest_uid != cfg.own_uid) & ~down_hit;
  assign fwd       = up_fwd | down_fwd;

  assign chan_next = ((chan_q == '0) && (in_q.msg_type == cfg.code_ack)) ?
                     in_q.hdr_channel : chan_q;

  always_comb begin
    res_d  = '0;
    user_d = '0;
    res_d.learned_channel = chan_next;
    if (fwd) begin
      user_d.forward        = 1'b1;
      user_d.toward_device  = down_fwd;
      res_d.out_sender_addr = own_addr;
      res_d.send_delay_us   = DELAY_W'(cfg.slot_number) * SLOT_TIME_US;
      if (up_fwd && first_hop) begin
        res_d.out_tag_a = in_q.rssi - in_q.nf_dbm;
        res_d.out_tag_b = in_q.sender_addr;
        res_d.out_tag_c = own_addr;
      end else begin
        res_d.out_tag_a = in_q.in_tag_a;
        res_d.out_tag_b = in_q.in_tag_b;
        res_d.out_tag_c = in_q.in_tag_c;
      end
    end
  end

  always_comb begin
    in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (m_accept ? 1'b0 : out_valid_q);
    chan_d      = advance ? chan_next : chan_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q <= hdr_word_t'(s_axis_tdata);
    end
    if (advance) begin
      res_q  <= res_d;
      user_q <= user_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chan_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      chan_q      <= chan_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = user_q;

endmodule

FILE: sv/mrdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrdf_checker: port-level checks for the repeater unit
// Watches the stream and configuration ports; attached by bind.
// ----------------------------------------------------------------------------
module mrdf_checker
  import mrdf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [1:0]       m_axis_tuser,
  input logic             pready
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // drop: everything but the learned channel is zero
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[51:0] == 52'd0 && !m_axis_tuser[1])
    else $error("dropped word carries forward fields");

  // empty result side never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // once learned, the channel does not change
  a_chan_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[59:52] != 8'd0 |=>
      !m_axis_tvalid || m_axis_tdata[59:52] == $past(m_axis_tdata[59:52]))
    else $error("learned channel changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind mesh_repeater_dedup_forward_unit mrdf_checker u_mrdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
